@@ rtl/core/cts_pkg.sv @@
// ----------------------------------------------------------------------------
// cts_pkg
// Shared constants, types and helpers of the text console engine.
// ----------------------------------------------------------------------------
package cts_pkg;

	localparam int COLS   = 80;
	localparam int ROWS   = 25;
	localparam int NCELLS = ROWS * COLS;

	localparam int RW     = $clog2(ROWS);       // physical/logical row index
	localparam int CW     = $clog2(COLS);       // column index
	localparam int FW     = $clog2(COLS + 1);   // per-row fill count
	localparam int AW     = $clog2(NCELLS);     // screen store address
	localparam int QDEPTH = 2;                  // front-to-back queue depth

	localparam logic [7:0] NEWLINE_CODE = 8'h0A;
	localparam logic [7:0] SPACE_CODE   = 8'h20;
	localparam logic [7:0] RESET_ATTR   = 8'h07;

	localparam logic CMD_PUT  = 1'b0;
	localparam logic CMD_READ = 1'b1;

	// register select, taken from paddr[2]
	localparam logic REG_FOREGROUND = 1'b0;
	localparam logic REG_BACKGROUND = 1'b1;

	typedef enum logic [1:0] {
		OP_PUT,
		OP_NEWLINE,
		OP_READ,
		OP_READ_OOB
	} op_t;

	typedef struct packed {
		op_t             op;
		logic [7:0]      char_code;
		logic [RW-1:0]   row;
		logic [CW-1:0]   col;
	} item_t;

	typedef struct packed {
		logic [3:0] fg;
		logic [3:0] bg;
	} colors_t;

	typedef struct packed {
		logic        scrolled;
		logic [15:0] cell_value;
		logic [4:0]  cursor_row_out;
		logic [6:0]  cursor_col_out;
	} result_t;

	// logical row -> physical row of the row-offset ring
	function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] row,
		input logic [RW-1:0] top);
		logic [RW:0] s;
		s = {1'b0, row} + {1'b0, top};
		if (32'(s) >= ROWS)
			s = s - (RW+1)'(ROWS);
		return s[RW-1:0];
	endfunction

	function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] prow,
		input logic [CW-1:0] col);
		return AW'(32'(prow) * COLS + 32'(col));
	endfunction

endpackage

@@ rtl/core/cts_ram.sv @@
// ----------------------------------------------------------------------------
// cts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cts_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/core/cts_front.sv @@
// ----------------------------------------------------------------------------
// cts_front
// Accepts input items, classifies them and hands them to the queue.
// ----------------------------------------------------------------------------
module cts_front import cts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,
	input  logic        s_tuser,
	output logic        push,
	output item_t       push_item,
	input  logic        q_ready
);

	logic        v_s1;
	item_t       item_s1;
	item_t       dec;
	logic [7:0]  char_code;
	logic [4:0]  read_row;
	logic [6:0]  read_col;

	assign char_code = s_tdata[7:0];
	assign read_row  = s_tdata[12:8];
	assign read_col  = s_tdata[19:13];

	always_comb begin
		dec.char_code = char_code;
		dec.row       = RW'(read_row);
		dec.col       = CW'(read_col);
		if (s_tuser == CMD_READ) begin
			if (32'(read_row) < ROWS && 32'(read_col) < COLS)
				dec.op = OP_READ;
			else
				dec.op = OP_READ_OOB;
		end else if (char_code == NEWLINE_CODE) begin
			dec.op = OP_NEWLINE;
		end else begin
			dec.op = OP_PUT;
		end
	end

	assign push      = v_s1 && q_ready;
	assign push_item = item_s1;
	assign s_tready  = !v_s1 || q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				v_s1 <= 1'b1;
			else if (push)
				v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			item_s1 <= dec;
	end

endmodule

@@ rtl/core/cts_queue.sv @@
// ----------------------------------------------------------------------------
// cts_queue
// Short FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
module cts_queue import cts_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  q_ready,
	input  logic  pop,
	output logic  q_valid,
	output item_t q_item
);

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int NW = $clog2(QDEPTH + 1);

	item_t          entry_q [QDEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [NW-1:0]  count_q;

	assign q_ready = 32'(count_q) < QDEPTH;
	assign q_valid = count_q != '0;
	assign q_item  = entry_q[rd_ptr_q];

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		return (32'(p) == QDEPTH - 1) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop)
				rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_item;
	end

endmodule

@@ rtl/core/cts_back.sv @@
// ----------------------------------------------------------------------------
// cts_back
// Executes items: cursor, row-offset ring, screen store and result register.
// ----------------------------------------------------------------------------
module cts_back import cts_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  colors_t colors,
	input  logic    q_valid,
	input  item_t   q_item,
	output logic    pop,
	output logic    m_tvalid,
	input  logic    m_tready,
	output result_t result
);

	typedef enum logic {ST_EXEC, ST_RD_WAIT} state_t;

	state_t          state_q;
	logic [CW-1:0]   cursor_col_q;
	logic [RW-1:0]   cursor_row_q;
	logic [RW-1:0]   top_q;
	logic [FW-1:0]   fill_q [ROWS];
	logic [7:0]      attr_q [ROWS];
	logic            m_valid_q;
	result_t         result_q;
	logic            hit_q;
	logic [7:0]      blank_q;

	logic            out_free;
	logic            exec;
	logic            res_load;
	logic [RW-1:0]   cur_prow;
	logic [RW-1:0]   rd_prow;
	logic [CW:0]     col_inc;
	logic            row_adv;
	logic            scroll;
	logic [CW-1:0]   next_col;
	logic [RW-1:0]   next_row;
	logic [RW-1:0]   next_top;
	logic            ram_we;
	logic            ram_re;
	logic [AW-1:0]   ram_waddr;
	logic [AW-1:0]   ram_raddr;
	logic [15:0]     ram_wdata;
	logic [15:0]     ram_rdata;

	assign out_free = !m_valid_q || m_tready;
	assign exec     = (state_q == ST_EXEC) && q_valid && out_free;
	assign pop      = exec;
	assign m_tvalid = m_valid_q;
	assign result   = result_q;

	// result register is loaded by every item but a screen read, which loads it
	// in the cycle after, from the wait state
	assign res_load = (exec && (q_item.op != OP_READ)) || (state_q == ST_RD_WAIT);

	always_comb begin
		cur_prow = phys_row(cursor_row_q, top_q);
		rd_prow  = phys_row(q_item.row, top_q);
		col_inc  = {1'b0, cursor_col_q} + 1'b1;
		if (q_item.op == OP_NEWLINE) begin
			next_col = '0;
			row_adv  = 1'b1;
		end else if (32'(col_inc) == COLS) begin
			next_col = '0;
			row_adv  = 1'b1;
		end else begin
			next_col = col_inc[CW-1:0];
			row_adv  = 1'b0;
		end
		scroll = row_adv && (32'(cursor_row_q) == ROWS - 1);
		if (row_adv && !scroll)
			next_row = cursor_row_q + 1'b1;
		else
			next_row = cursor_row_q;
		next_top = (32'(top_q) == ROWS - 1) ? '0 : top_q + 1'b1;
	end

	assign ram_we    = exec && (q_item.op == OP_PUT);
	assign ram_waddr = cell_addr(cur_prow, cursor_col_q);
	assign ram_wdata = {colors.bg, colors.fg, q_item.char_code};
	assign ram_re    = exec && (q_item.op == OP_READ);
	assign ram_raddr = cell_addr(rd_prow, q_item.col);

	cts_ram #(
		.WIDTH(16),
		.DEPTH(NCELLS)
	) u_screen (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_EXEC;
			cursor_col_q <= '0;
			cursor_row_q <= '0;
			top_q        <= '0;
			m_valid_q    <= 1'b0;
			for (int r = 0; r < ROWS; r++) begin
				fill_q[r] <= '0;
				attr_q[r] <= RESET_ATTR;
			end
		end else begin
			if (res_load)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;
			unique case (state_q)
				ST_EXEC: begin
					if (exec) begin
						case (q_item.op) inside
							OP_PUT, OP_NEWLINE: begin
								cursor_col_q <= next_col;
								cursor_row_q <= next_row;
								if (q_item.op == OP_PUT)
									fill_q[cur_prow] <= FW'(col_inc);
								if (scroll) begin
									// oldest physical row becomes the blank bottom row
									top_q          <= next_top;
									fill_q[top_q]  <= '0;
									attr_q[top_q]  <= {colors.bg, colors.fg};
								end
								result_q.cursor_col_out <= 7'(next_col);
								result_q.cursor_row_out <= 5'(next_row);
								result_q.cell_value     <= '0;
								result_q.scrolled       <= scroll;
							end
							OP_READ: begin
								hit_q   <= 32'(q_item.col) < 32'(fill_q[rd_prow]);
								blank_q <= attr_q[rd_prow];
								state_q <= ST_RD_WAIT;
							end
							default: begin
								result_q.cursor_col_out <= 7'(cursor_col_q);
								result_q.cursor_row_out <= 5'(cursor_row_q);
								result_q.cell_value     <= '0;
								result_q.scrolled       <= 1'b0;
							end
						endcase
					end
				end
				ST_RD_WAIT: begin
					result_q.cursor_col_out <= 7'(cursor_col_q);
					result_q.cursor_row_out <= 5'(cursor_row_q);
					result_q.cell_value     <= hit_q ? ram_rdata : {blank_q, SPACE_CODE};
					result_q.scrolled       <= 1'b0;
					state_q                 <= ST_EXEC;
				end
				default: state_q <= ST_EXEC;
			endcase
		end
	end

	a_cursor_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cursor_col_q) < COLS && 32'(cursor_row_q) < ROWS && 32'(top_q) < ROWS)
		else $error("cursor or ring offset out of range");

	a_rd_wait_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RD_WAIT |-> !m_valid_q)
		else $error("read result would overwrite a pending item");

	a_scroll_bottom: assert property (@(posedge clk) disable iff (!arst_n)
		exec && (q_item.op == OP_PUT || q_item.op == OP_NEWLINE) && scroll
		|=> 32'(cursor_row_q) == ROWS - 1 && m_valid_q && result_q.scrolled)
		else $error("scroll did not leave cursor on bottom row");

	a_no_pop_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		$past(ram_re) |-> state_q == ST_RD_WAIT)
		else $error("read issued without entering wait state");

endmodule

@@ rtl/core/text_console_cursor_scroll_top.sv @@
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_top
// Text-mode console engine: screen store of character cells plus cursor.
// ----------------------------------------------------------------------------
// Path: a put or newline result passes the front register, the queue and
//   the back execute loading the result register; a read result also
//   passes the registered store read.
// Throughput: one put/newline per cycle unless results stall; a read holds
//   the back FSM waiting on the screen RAM read port before the next item.
// Reset: cursor at row 0 column 0, colours 7 on 0, every cell reads as a
//   light grey space at once through per-row fill counts; no clearing pass.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_top import cts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // char_code[7:0], read_row[12:8], read_col[19:13]
	input  logic        s_tuser,   // cmd[0]
	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // cursor_col_out[6:0], cursor_row_out[11:7],
	                               // cell_value[27:12], scrolled[28]
);

	logic [3:0] fg_q;
	logic [3:0] bg_q;
	colors_t    colors;

	logic       push;
	item_t      push_item;
	logic       q_ready;
	logic       pop;
	logic       q_valid;
	item_t      q_item;
	result_t    result;

	// Config registers: foreground at byte 0, background at byte 4.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q <= 4'd7;
			bg_q <= 4'd0;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				REG_FOREGROUND: fg_q <= pwdata[3:0];
				REG_BACKGROUND: bg_q <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_FOREGROUND: prdata = {28'd0, fg_q};
			REG_BACKGROUND: prdata = {28'd0, bg_q};
			default:        prdata = '0;
		endcase
	end

	assign colors.fg = fg_q;
	assign colors.bg = bg_q;

	// Front: accept and classify (put / newline / read / out-of-screen read).
	cts_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.push      (push),
		.push_item (push_item),
		.q_ready   (q_ready)
	);

	// Queue decouples front stalls from back stalls.
	cts_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.q_ready   (q_ready),
		.pop       (pop),
		.q_valid   (q_valid),
		.q_item    (q_item)
	);

	// Back: cursor, row ring (scroll = bump top row, blank the old top),
	// screen store and the result register.
	cts_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.colors   (colors),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.result   (result)
	);

	assign m_tdata = {3'd0, result};

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the text console engine. Put and read items go in
// on the input stream; each result item is checked field by field against a
// software copy of the screen, cursor and colours kept in a scoreboard class.
// The run covers several colour settings written over APB.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import cts_pkg::*;

	// screen mirror plus the queue of results still owed by the block
	class console_scoreboard;
		logic [15:0] cells [NCELLS];
		int unsigned cur_col;
		int unsigned cur_row;
		logic [3:0]  fg;
		logic [3:0]  bg;
		result_t     awaited [$];
		int unsigned errors;

		function new();
			foreach (cells[i])
				cells[i] = {RESET_ATTR, SPACE_CODE};
			cur_col = 0;
			cur_row = 0;
			fg      = 4'd7;
			bg      = 4'd0;
			errors  = 0;
		endfunction

		function void set_color(logic reg_sel, logic [3:0] value);
			if (reg_sel == REG_FOREGROUND)
				fg = value;
			else
				bg = value;
		endfunction

		function int backlog();
			return awaited.size();
		endfunction

		// apply one accepted input item and queue the result it must produce
		function void note_item(logic cmd, logic [7:0] ch, logic [4:0] rr,
			logic [6:0] rc);
			result_t r;
			r = '0;
			if (cmd == CMD_READ) begin
				if (rr < ROWS && rc < COLS)
					r.cell_value = cells[rr * COLS + rc];
			end else begin
				if (ch == NEWLINE_CODE) begin
					cur_col = 0;
					cur_row++;
				end else begin
					cells[cur_row * COLS + cur_col] = {bg, fg, ch};
					cur_col++;
				end
				if (cur_col >= COLS) begin
					cur_col = 0;
					cur_row++;
				end
				if (cur_row >= ROWS) begin
					// rows move up one, bottom row goes blank in current colours
					for (int i = 0; i < NCELLS - COLS; i++)
						cells[i] = cells[i + COLS];
					for (int i = NCELLS - COLS; i < NCELLS; i++)
						cells[i] = {bg, fg, SPACE_CODE};
					cur_row = ROWS - 1;
					r.scrolled = 1'b1;
				end
			end
			r.cursor_col_out = 7'(cur_col);
			r.cursor_row_out = 5'(cur_row);
			awaited.push_back(r);
		endfunction

		function void compare(string what, int unsigned want, int unsigned seen);
			if (want != seen) begin
				$display("%0t: %s mismatch, expected 0x%0h actual 0x%0h",
					$time, what, want, seen);
				errors++;
			end
		endfunction

		function void check_result(logic [31:0] data);
			result_t got;
			result_t want;
			got = result_t'(data[28:0]);
			if (awaited.size() == 0) begin
				$display("%0t: result 0x%0h with nothing expected, expected none actual 0x%0h",
					$time, data, data);
				errors++;
				return;
			end
			want = awaited.pop_front();
			compare("cursor_col_out", want.cursor_col_out, got.cursor_col_out);
			compare("cursor_row_out", want.cursor_row_out, got.cursor_row_out);
			compare("cell_value", want.cell_value, got.cell_value);
			compare("scrolled", want.scrolled, got.scrolled);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // char_code[7:0], read_row[12:8], read_col[19:13]
	logic        s_tuser;   // cmd[0]
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // cursor_col_out[6:0], cursor_row_out[11:7],
	                        // cell_value[27:12], scrolled[28]

	console_scoreboard board;
	bit          quiet;       // no idling on either side in the closing phase
	int unsigned results_seen;

	text_console_cursor_scroll_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// 10 ns clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// hard stop in case the block hangs
	initial begin
		#5_000_000;
		$display("testbench failed");
		$finish;
	end

	// --------------------------------------------------------------------
	// Drivers. All inputs change by nonblocking assignment right after a
	// rising edge; handshakes are sampled in the active region of the edge,
	// so they see the values the block saw.
	// --------------------------------------------------------------------

	// APB write: setup cycle, then access until pready
	task automatic apb_write(logic reg_sel, logic [3:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_sel, 2'b00};
		pwdata  <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		board.set_color(reg_sel, value);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// offer one item and hold it until accepted; tvalid stays high afterwards
	task automatic push_item(logic cmd, logic [7:0] ch, logic [4:0] rr,
		logic [6:0] rc);
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {4'b0000, rc, rr, ch};
		do @(posedge clk); while (!s_tready);
		board.note_item(cmd, ch, rr, rc);
	endtask

	task automatic sender_gap(int unsigned cycles);
		s_tvalid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// sender pauses until every owed result is back, then lets the
	// pipeline settle before touching registers
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (board.backlog() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Random item. Reads lean on the cursor row so fresh writes and
	// scrolled rows get read back; a tenth use the full field range, which
	// covers the off-screen reads. Newlines are boosted so scrolling is common.
	task automatic random_item();
		int unsigned pick;
		logic        cmd;
		logic [7:0]  ch;
		logic [4:0]  rr;
		logic [6:0]  rc;
		pick = $urandom_range(0, 99);
		cmd  = (pick < 35) ? CMD_READ : CMD_PUT;
		ch   = (pick >= 35 && pick < 45) ? NEWLINE_CODE : 8'($urandom);
		case ($urandom_range(0, 9))
			0: begin
				rr = 5'($urandom);
				rc = 7'($urandom);
			end
			1, 2, 3: begin
				rr = 5'(board.cur_row);
				rc = 7'($urandom_range(0, COLS - 1));
			end
			default: begin
				rr = 5'($urandom_range(0, ROWS - 1));
				rc = 7'($urandom_range(0, COLS - 1));
			end
		endcase
		push_item(cmd, ch, rr, rc);
	endtask

	// result side: random stalls, plus one long hold-off early on so the
	// block backs up and drops s_tready while the sender keeps offering
	initial begin
		int unsigned stall_left;
		bit          held;
		stall_left   = 0;
		held         = 1'b0;
		results_seen = 0;
		m_tready    <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				board.check_result(m_tdata);
				results_seen++;
			end
			if (stall_left != 0)
				stall_left--;
			else if (results_seen >= 450 && !held) begin
				stall_left = 300;
				held       = 1'b1;
			end else if (!quiet && $urandom_range(0, 9) == 0)
				stall_left = $urandom_range(1, 15);
			m_tready <= arst_n && (stall_left == 0);
		end
	end

	// --------------------------------------------------------------------
	// Main sequence
	// --------------------------------------------------------------------
	initial begin
		logic [3:0] fg_set;
		logic [3:0] bg_set;
		board    = new();
		quiet    = 1'b0;
		arst_n   = 1'b0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		s_tvalid <= 1'b0;
		s_tuser  <= CMD_PUT;
		s_tdata  <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset contents, corners, off-screen reads, byte extremes
		push_item(CMD_READ, 8'h00, 5'd0, 7'd0);
		push_item(CMD_READ, 8'hFF, 5'(ROWS - 1), 7'(COLS - 1));
		push_item(CMD_READ, 8'h00, 5'(ROWS), 7'd0);
		push_item(CMD_READ, 8'h00, 5'd0, 7'(COLS));
		push_item(CMD_READ, 8'h00, 5'h1F, 7'h7F);
		push_item(CMD_PUT, 8'h00, 5'h1F, 7'h7F);
		push_item(CMD_PUT, 8'hFF, 5'd0, 7'd0);
		push_item(CMD_PUT, 8'h41, 5'd0, 7'd0);
		push_item(CMD_PUT, NEWLINE_CODE, 5'd0, 7'd0);
		push_item(CMD_PUT, 8'h5A, 5'd0, 7'd0);
		push_item(CMD_READ, 8'h00, 5'd0, 7'd0);
		push_item(CMD_READ, 8'h00, 5'd0, 7'd1);
		push_item(CMD_READ, 8'h00, 5'd0, 7'd2);
		push_item(CMD_READ, 8'h00, 5'd1, 7'd0);
		push_item(CMD_READ, 8'h00, 5'd1, 7'd1);
		drain_results();

		// colour phases: reset colours, both extremes, mixed, then random
		for (int phase = 0; phase < 6; phase++) begin
			if (phase != 0) begin
				case (phase)
					1: begin fg_set = 4'h0; bg_set = 4'h0; end
					2: begin fg_set = 4'hF; bg_set = 4'hF; end
					3: begin fg_set = 4'hF; bg_set = 4'h0; end
					default: begin
						fg_set = 4'($urandom);
						bg_set = 4'($urandom);
					end
				endcase
				apb_write(REG_FOREGROUND, fg_set);
				apb_write(REG_BACKGROUND, bg_set);
			end
			quiet = (phase == 5);
			for (int n = 0; n < 330; n++) begin
				random_item();
				// gaps come in bursts; some phases stretch without any
				if (!quiet && phase != 2 && $urandom_range(0, 7) == 0)
					sender_gap($urandom_range(1, 15));
			end
			drain_results();
		end

		if (board.errors == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
